### hdl/ebml_pkg.sv
// Shared types, codes and helpers for the EBML element stream parser.
package ebml_pkg;

    localparam int MAX_NEST_DEFAULT = 8;

    localparam logic [2:0] KIND_HEADER   = 3'd0;
    localparam logic [2:0] KIND_WIDTH    = 3'd1;
    localparam logic [2:0] KIND_HEIGHT   = 3'd2;
    localparam logic [2:0] KIND_ID_ERR   = 3'd3;
    localparam logic [2:0] KIND_SIZE_ERR = 3'd4;
    localparam logic [2:0] KIND_TRUNC    = 3'd5;
    localparam logic [2:0] KIND_OVERFLOW = 3'd6;

    localparam logic [31:0] ID_EBML_HEADER  = 32'h1A45DFA3;
    localparam logic [31:0] ID_SEGMENT      = 32'h18538067;
    localparam logic [31:0] ID_TRACKS       = 32'h1654AE6B;
    localparam logic [31:0] ID_TRACK_ENTRY  = 32'h000000AE;
    localparam logic [31:0] ID_VIDEO        = 32'h000000E0;
    localparam logic [31:0] ID_PIXEL_WIDTH  = 32'h000000B0;
    localparam logic [31:0] ID_PIXEL_HEIGHT = 32'h000000BA;

    // Smallest first byte of a valid ID (IDs are at most four bytes long).
    localparam logic [7:0] ID_FIRST_MIN = 8'h10;

    typedef enum logic [5:0] {
        PH_EXPECT     = 6'b000001,
        PH_ID         = 6'b000010,
        PH_SIZE_FIRST = 6'b000100,
        PH_SIZE_MORE  = 6'b001000,
        PH_PIXEL      = 6'b010000,
        PH_SKIP       = 6'b100000
    } phase_t;

    typedef struct packed {
        logic [2:0]  result_kind;
        logic [31:0] element_code;
        logic [2:0]  id_bytes;
        logic [55:0] payload_size;
        logic [3:0]  size_bytes;
        logic [63:0] pixel_count;
        logic [3:0]  nest_level;
        logic        run_end;
    } result_t;

    // Up to two result words produced by one byte, in order.
    typedef struct packed {
        logic [1:0] count;
        result_t    first;
        result_t    second;
    } result_pair_t;

    function automatic result_t make_result(
        input logic [2:0]  kind,
        input logic [31:0] code,
        input logic [2:0]  idb,
        input logic [55:0] psize,
        input logic [3:0]  sb,
        input logic [63:0] pix,
        input logic [3:0]  level
    );
        result_t r;
        r.result_kind  = kind;
        r.element_code = code;
        r.id_bytes     = idb;
        r.payload_size = psize;
        r.size_bytes   = sb;
        r.pixel_count  = pix;
        r.nest_level   = level;
        r.run_end      = 1'b0;
        return r;
    endfunction

    // Count of zero bits above the highest set bit; the byte is never zero here.
    function automatic logic [2:0] lead_zeros(input logic [7:0] b);
        logic [2:0] lz;
        lz = 3'd7;
        for (int i = 0; i < 8; i++) begin
            if (b[i]) begin
                lz = 3'(7 - i);
            end
        end
        return lz;
    endfunction

    function automatic logic is_container(input logic [31:0] id);
        return (id == ID_EBML_HEADER) || (id == ID_SEGMENT) || (id == ID_TRACKS) ||
               (id == ID_TRACK_ENTRY) || (id == ID_VIDEO);
    endfunction

endpackage

### hdl/ebml_end_stack.sv
// Stack of open container end offsets with a parallel compare against the byte offset.
module ebml_end_stack #(
    parameter int MAX_NEST = ebml_pkg::MAX_NEST_DEFAULT,
    parameter int DW = $clog2(MAX_NEST + 1),
    parameter int IW = $clog2(MAX_NEST)
) (
    input  logic          aclk,
    input  logic          push_en,
    input  logic [IW-1:0] push_index,
    input  logic [63:0]   push_end,
    input  logic [DW-1:0] depth,
    input  logic [63:0]   position,
    output logic [DW-1:0] pop_depth
);
    import ebml_pkg::*;

    logic [63:0]         end_reg [MAX_NEST];
    logic [MAX_NEST-1:0] still_open;

    always_ff @(posedge aclk) begin
        if (push_en) begin
            end_reg[push_index] <= push_end;
        end
    end

    // A level stays open while its end lies beyond the current offset. Levels
    // are popped from the top down to the highest one that is still open.
    always_comb begin
        for (int j = 0; j < MAX_NEST; j++) begin
            still_open[j] = (DW'(j) < depth) && (end_reg[j] > position);
        end
        pop_depth = '0;
        for (int j = 0; j < MAX_NEST; j++) begin
            if (still_open[j]) begin
                pop_depth = DW'(j + 1);
            end
        end
    end

endmodule

### hdl/ebml_parser_core.sv
// Per-byte parse state and the decode of ID, size and payload bytes into results.
module ebml_parser_core #(
    parameter int MAX_NEST = ebml_pkg::MAX_NEST_DEFAULT,
    parameter int DW = $clog2(MAX_NEST + 1),
    parameter int IW = $clog2(MAX_NEST)
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   fire,
    input  logic [7:0]             data_byte,
    input  logic                   final_byte,
    input  logic [DW-1:0]          pop_depth,
    output logic [DW-1:0]          nest_depth,
    output logic [63:0]            byte_position,
    output logic                   push_en,
    output logic [IW-1:0]          push_index,
    output logic [63:0]            push_end,
    output ebml_pkg::result_pair_t results
);
    import ebml_pkg::*;

    phase_t        phase_reg, phase_next;
    logic [31:0]   id_reg, id_next;
    logic [1:0]    id_left_reg, id_left_next;
    logic [2:0]    id_len_reg, id_len_next;
    logic [55:0]   size_reg, size_next;
    logic [2:0]    size_left_reg, size_left_next;
    logic [3:0]    size_len_reg, size_len_next;
    logic [63:0]   pos_reg, pos_next;
    logic [55:0]   left_reg, left_next;
    logic [63:0]   value_reg, value_next;
    logic [DW-1:0] depth_reg, depth_next;
    logic          halted_reg, halted_next;

    logic [2:0]    lz;
    logic          size_done;
    logic [55:0]   sz;
    logic [1:0]    n_main;
    result_t       res_a, res_b, trunc;
    logic          trunc_en;
    logic [2:0]    pix_kind;
    logic [55:0]   miss;

    assign nest_depth    = depth_reg;
    assign byte_position = pos_reg;
    assign push_index    = depth_reg[IW-1:0];
    assign lz            = lead_zeros(data_byte);
    assign pix_kind      = (id_reg == ID_PIXEL_WIDTH) ? KIND_WIDTH : KIND_HEIGHT;

    always_comb begin
        phase_next     = phase_reg;
        id_next        = id_reg;
        id_left_next   = id_left_reg;
        id_len_next    = id_len_reg;
        size_next      = size_reg;
        size_left_next = size_left_reg;
        size_len_next  = size_len_reg;
        pos_next       = pos_reg;
        left_next      = left_reg;
        value_next     = value_reg;
        depth_next     = depth_reg;
        halted_next    = halted_reg;
        size_done      = 1'b0;
        sz             = '0;
        n_main         = 2'd0;
        res_a          = '0;
        res_b          = '0;
        trunc          = '0;
        trunc_en       = 1'b0;
        miss           = '0;
        push_en        = 1'b0;
        push_end       = '0;

        if (fire) begin
            pos_next = pos_reg + 64'd1;
            if (!halted_reg) begin
                case (phase_reg)
                    PH_EXPECT: begin
                        depth_next = pop_depth;
                        if (data_byte < ID_FIRST_MIN) begin
                            res_a  = make_result(KIND_ID_ERR, {24'd0, data_byte}, 3'd0,
                                                 56'd0, 4'd0, 64'd0, 4'(pop_depth));
                            n_main = 2'd1;
                            if (pop_depth != '0) begin
                                depth_next = pop_depth - DW'(1);
                            end else begin
                                halted_next = 1'b1;
                            end
                        end else begin
                            id_next      = {24'd0, data_byte};
                            id_len_next  = lz + 3'd1;
                            id_left_next = lz[1:0];
                            phase_next   = (lz != 3'd0) ? PH_ID : PH_SIZE_FIRST;
                        end
                    end
                    PH_ID: begin
                        id_next      = {id_reg[23:0], data_byte};
                        id_left_next = id_left_reg - 2'd1;
                        if (id_left_next == 2'd0) begin
                            phase_next = PH_SIZE_FIRST;
                        end
                    end
                    PH_SIZE_FIRST: begin
                        if (data_byte == 8'd0) begin
                            res_a      = make_result(KIND_SIZE_ERR, id_reg, id_len_reg, 56'd0,
                                                     4'd0, 64'd0, 4'(depth_reg));
                            n_main     = 2'd1;
                            phase_next = PH_EXPECT;
                            if (depth_reg != '0) begin
                                depth_next = depth_reg - DW'(1);
                            end else begin
                                halted_next = 1'b1;
                            end
                        end else begin
                            sz             = {48'd0, data_byte & (8'h7F >> lz)};
                            size_next      = sz;
                            size_len_next  = {1'b0, lz} + 4'd1;
                            size_left_next = lz;
                            if (lz == 3'd0) begin
                                size_done = 1'b1;
                            end else begin
                                phase_next = PH_SIZE_MORE;
                            end
                        end
                    end
                    PH_SIZE_MORE: begin
                        sz             = {size_reg[47:0], data_byte};
                        size_next      = sz;
                        size_left_next = size_left_reg - 3'd1;
                        if (size_left_next == 3'd0) begin
                            size_done = 1'b1;
                        end
                    end
                    PH_PIXEL: begin
                        value_next = {value_reg[55:0], data_byte};
                        left_next  = left_reg - 56'd1;
                        if (left_next == 56'd0) begin
                            res_a      = make_result(pix_kind, id_reg, id_len_reg, size_reg,
                                                     size_len_reg, value_next, 4'(depth_reg));
                            n_main     = 2'd1;
                            phase_next = PH_EXPECT;
                        end
                    end
                    PH_SKIP: begin
                        if (left_reg != 56'd0) begin
                            left_next = left_reg - 56'd1;
                        end
                        if (left_next == 56'd0) begin
                            phase_next = PH_EXPECT;
                        end
                    end
                    default: begin
                        phase_next = PH_EXPECT;
                    end
                endcase
            end

            if (size_done) begin
                phase_next = PH_EXPECT;
                n_main     = 2'd1;
                res_a      = make_result(KIND_HEADER, id_reg, id_len_reg, sz, size_len_next,
                                         64'd0, 4'(depth_reg));
                if (is_container(id_reg)) begin
                    if (depth_reg >= DW'(MAX_NEST)) begin
                        // No room for another level: report it and skip the content.
                        res_a.result_kind = KIND_OVERFLOW;
                        left_next = sz;
                        if (sz != 56'd0) begin
                            phase_next = PH_SKIP;
                        end
                    end else begin
                        push_en    = 1'b1;
                        push_end   = pos_next + {8'd0, sz};
                        depth_next = depth_reg + DW'(1);
                    end
                end else if ((id_reg == ID_PIXEL_WIDTH) || (id_reg == ID_PIXEL_HEIGHT)) begin
                    value_next = '0;
                    left_next  = sz;
                    if (sz == 56'd0) begin
                        res_b  = make_result(pix_kind, id_reg, id_len_reg, sz, size_len_next,
                                             64'd0, 4'(depth_reg));
                        n_main = 2'd2;
                    end else begin
                        phase_next = PH_PIXEL;
                    end
                end else begin
                    left_next = sz;
                    if (sz != 56'd0) begin
                        phase_next = PH_SKIP;
                    end
                end
            end

            if (final_byte) begin
                if (!halted_next && (phase_next != PH_EXPECT)) begin
                    if ((phase_next == PH_PIXEL) || (phase_next == PH_SKIP)) begin
                        miss = left_next;
                    end
                    trunc    = make_result(KIND_TRUNC, id_next, 3'd0, miss, 4'd0, 64'd0,
                                           4'(depth_next));
                    trunc_en = 1'b1;
                end
                // The file ends here: start over for the next one.
                phase_next  = PH_EXPECT;
                pos_next    = '0;
                depth_next  = '0;
                halted_next = 1'b0;
            end
        end

        results.count  = n_main + {1'b0, trunc_en};
        results.first  = (n_main != 2'd0) ? res_a : trunc;
        results.second = (n_main == 2'd2) ? res_b : trunc;
        if (results.count == 2'd1) begin
            results.first.run_end = 1'b1;
        end
        if (results.count == 2'd2) begin
            results.second.run_end = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_EXPECT;
            pos_reg    <= '0;
            depth_reg  <= '0;
            halted_reg <= 1'b0;
        end else begin
            phase_reg  <= phase_next;
            pos_reg    <= pos_next;
            depth_reg  <= depth_next;
            halted_reg <= halted_next;
        end
    end

    always_ff @(posedge aclk) begin
        id_reg        <= id_next;
        id_left_reg   <= id_left_next;
        id_len_reg    <= id_len_next;
        size_reg      <= size_next;
        size_left_reg <= size_left_next;
        size_len_reg  <= size_len_next;
        left_reg      <= left_next;
        value_reg     <= value_next;
    end

endmodule

### hdl/ebml_result_queue.sv
// Four-entry result queue that takes up to two words per cycle and sends one.
module ebml_result_queue (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  ebml_pkg::result_pair_t results,
    output logic                   room,
    output logic                   out_valid,
    input  logic                   out_ready,
    output ebml_pkg::result_t      out_word
);
    import ebml_pkg::*;

    localparam int QD = 4;
    localparam int PW = $clog2(QD);

    result_t       entry_reg [QD];
    logic [PW-1:0] head_reg, head_next;
    logic [PW-1:0] tail_reg, tail_next;
    logic [PW:0]   count_reg, count_next;
    logic          pop;

    assign out_valid = (count_reg != '0);
    assign out_word  = entry_reg[head_reg];
    assign pop       = out_valid && out_ready;
    // Room is judged on the registered count so that a byte never waits on out_ready.
    assign room      = (count_reg <= (PW + 1)'(QD - 2));

    always_comb begin
        head_next  = pop ? head_reg + PW'(1) : head_reg;
        tail_next  = tail_reg + PW'(results.count);
        count_next = count_reg + (PW + 1)'(results.count) - (PW + 1)'(pop);
    end

    always_ff @(posedge aclk) begin
        if (results.count != 2'd0) begin
            entry_reg[tail_reg] <= results.first;
        end
        if (results.count == 2'd2) begin
            entry_reg[tail_reg + PW'(1)] <= results.second;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end else begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

endmodule

### hdl/ebml_element_stream_parser_unit.sv
// Flow: an accepted byte waits in an input register and is parsed once the result queue
// has room; its results are written to the queue, which drives the master side.
// Throughput: one byte per cycle while the queue has room; a byte that causes two results
// sends them on the master port one after the other, buffered by a 4-word queue.
// Reset: aresetn (synchronous, active low) clears the parse state, nesting depth and
// queue; the end-offset stack is not cleared, as only entries below the depth are read.
module ebml_element_stream_parser_unit #(
    parameter int MAX_NEST = ebml_pkg::MAX_NEST_DEFAULT
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [7:0]   s_tdata,   // data_byte[7:0]
    input  logic         s_tlast,   // final_byte
    output logic         m_tvalid,
    input  logic         m_tready,
    // element_code[31:0], id_bytes[34:32], payload_size[90:35], size_bytes[94:91],
    // pixel_count[158:95], nest_level[162:159], zero fill[167:163]
    output logic [167:0] m_tdata,
    output logic [2:0]   m_tuser,   // result_kind[2:0]
    output logic         m_tlast    // run_end
);
    import ebml_pkg::*;

    localparam int DW = $clog2(MAX_NEST + 1);
    localparam int IW = $clog2(MAX_NEST);

    logic          in_valid_reg;
    logic [7:0]    in_byte_reg;
    logic          in_final_reg;
    logic          room;
    logic          fire;

    logic [DW-1:0] pop_depth;
    logic [DW-1:0] nest_depth;
    logic [63:0]   byte_position;
    logic          push_en;
    logic [IW-1:0] push_index;
    logic [63:0]   push_end;
    result_pair_t  results;
    result_t       out_word;

    assign fire     = in_valid_reg && room;
    assign s_tready = !in_valid_reg || fire;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_byte_reg  <= s_tdata;
            in_final_reg <= s_tlast;
        end
    end

    ebml_end_stack #(
        .MAX_NEST(MAX_NEST),
        .DW(DW),
        .IW(IW)
    ) u_stack (
        .aclk      (aclk),
        .push_en   (push_en),
        .push_index(push_index),
        .push_end  (push_end),
        .depth     (nest_depth),
        .position  (byte_position),
        .pop_depth (pop_depth)
    );

    ebml_parser_core #(
        .MAX_NEST(MAX_NEST),
        .DW(DW),
        .IW(IW)
    ) u_core (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .fire         (fire),
        .data_byte    (in_byte_reg),
        .final_byte   (in_final_reg),
        .pop_depth    (pop_depth),
        .nest_depth   (nest_depth),
        .byte_position(byte_position),
        .push_en      (push_en),
        .push_index   (push_index),
        .push_end     (push_end),
        .results      (results)
    );

    ebml_result_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .results  (results),
        .room     (room),
        .out_valid(m_tvalid),
        .out_ready(m_tready),
        .out_word (out_word)
    );

    assign m_tdata = {5'd0, out_word.nest_level, out_word.pixel_count, out_word.size_bytes,
                      out_word.payload_size, out_word.id_bytes, out_word.element_code};
    assign m_tuser = out_word.result_kind;
    assign m_tlast = out_word.run_end;

endmodule
